/* rtl/icf_pkg.sv */
// shared types, constants and crc helpers for the image crc framer
package icf_pkg;

   localparam int PAD_BLOCK  = 1024;
   localparam int FOOTER_LEN = 12;
   localparam int PHASE_W    = $clog2(PAD_BLOCK);
   localparam int LEFT_W     = $clog2(PAD_BLOCK + FOOTER_LEN);
   localparam int CMD_DEPTH  = 2;
   localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

   localparam logic [31:0] CRC_POLY_RESET   = 32'h2083_b8ed;
   localparam logic [31:0] MAGIC_WORD_RESET = 32'h1234_5678;
   localparam logic [31:0] CRC_INIT         = 32'hffff_ffff;
   localparam logic [7:0]  PAD_BYTE         = 8'hff;

   localparam logic [7:0] LZMA_SIG [4] = '{8'h5d, 8'h00, 8'h00, 8'h80};

   typedef enum logic [0:0] {
      REG_CRC_POLY   = 1'b0,
      REG_MAGIC_WORD = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_HDR_BAD = 2'd1,
      STATUS_REFUSED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CMD_DATA,
      CMD_REFUSE,
      CMD_PAD,
      CMD_LEN,
      CMD_MAGIC,
      CMD_CRC
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic [1:0]   sel;
      logic         last;
      status_type   status;
   } cmd_type;

   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   // reflected crc-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                            input logic [7:0]  b,
                                            input logic [31:0] poly);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? (poly ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] sel);
      return w[{sel, 3'b000} +: 8];
   endfunction

endpackage

/* rtl/icf_front.sv */
// front end: takes items, tracks frame length and trailer, issues commands
module icf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              mode,
   input  logic [7:0]        data_byte,
   input  logic              check_header,
   output icf_pkg::cmd_type  cmd
);

   localparam logic [icf_pkg::PHASE_W:0] BLOCK_EXT =
      (icf_pkg::PHASE_W + 1)'(icf_pkg::PAD_BLOCK);
   localparam logic [icf_pkg::PHASE_W:0] FOOT_EXT =
      (icf_pkg::PHASE_W + 1)'(icf_pkg::FOOTER_LEN);
   localparam logic [icf_pkg::PHASE_W-1:0] PHASE_LAST =
      icf_pkg::PHASE_W'(icf_pkg::PAD_BLOCK - 1);
   localparam logic [icf_pkg::LEFT_W-1:0] LEFT_FOOT =
      icf_pkg::LEFT_W'(icf_pkg::FOOTER_LEN);

   logic [31:0]                   count_ff, count_in;
   logic [icf_pkg::PHASE_W-1:0]   phase_ff, phase_in;
   logic                          trailer_ff, trailer_in;
   logic [icf_pkg::LEFT_W-1:0]    left_ff, left_in;
   logic                          check_ff, check_in;
   logic                          bad_ff, bad_in;

   logic [icf_pkg::PHASE_W:0]     rem_sum;
   logic [icf_pkg::PHASE_W:0]     rem;
   logic [icf_pkg::PHASE_W:0]     pad;
   logic [icf_pkg::LEFT_W-1:0]    left_cur;
   logic                          bad_cur;
   logic                          check_cur;
   logic [3:0]                    idx;
   logic                          early;

   // padding length from the running length mod block size
   always_comb begin
      rem_sum = {1'b0, phase_ff} + FOOT_EXT;
      rem     = (rem_sum >= BLOCK_EXT) ? (rem_sum - BLOCK_EXT) : rem_sum;
      pad     = (rem == '0) ? '0 : (BLOCK_EXT - rem);
   end

   always_comb begin
      count_in   = count_ff;
      phase_in   = phase_ff;
      trailer_in = trailer_ff;
      left_in    = left_ff;
      check_in   = check_ff;
      bad_in     = bad_ff;
      left_cur   = left_ff;
      bad_cur    = bad_ff;
      check_cur  = check_ff;
      early      = (count_ff < 32'd4);
      idx        = 4'(icf_pkg::FOOTER_LEN) - left_ff[3:0];
      cmd        = '{kind: icf_pkg::CMD_REFUSE, data: 8'd0, sel: 2'd0, last: 1'b0,
                     status: icf_pkg::STATUS_REFUSED};

      if (!mode) begin
         if (!trailer_ff) begin
            if (count_ff == 32'd0) begin
               check_cur = check_header;
            end
            bad_cur = bad_ff |
                      (check_cur && early && (data_byte != icf_pkg::LZMA_SIG[count_ff[1:0]]));
            check_in = check_cur;
            bad_in   = bad_cur;
            count_in = count_ff + 32'd1;
            if (count_ff == 32'hffff_ffff || phase_ff == PHASE_LAST) begin
               phase_in = '0;
            end else begin
               phase_in = phase_ff + 1'b1;
            end
            cmd.kind   = icf_pkg::CMD_DATA;
            cmd.data   = data_byte;
            cmd.status = bad_cur ? icf_pkg::STATUS_HDR_BAD : icf_pkg::STATUS_OK;
         end
      end else begin
         if (!trailer_ff) begin
            left_cur = icf_pkg::LEFT_W'(pad) + LEFT_FOOT;
            bad_cur  = bad_ff | (check_ff && early);
         end
         idx        = 4'(icf_pkg::FOOTER_LEN) - left_cur[3:0];
         cmd.sel    = idx[1:0];
         cmd.status = bad_cur ? icf_pkg::STATUS_HDR_BAD : icf_pkg::STATUS_OK;
         if (left_cur > LEFT_FOOT) begin
            cmd.kind = icf_pkg::CMD_PAD;
         end else begin
            case (idx[3:2])
               2'd0:    cmd.kind = icf_pkg::CMD_LEN;
               2'd1:    cmd.kind = icf_pkg::CMD_MAGIC;
               default: cmd.kind = icf_pkg::CMD_CRC;
            endcase
         end
         cmd.data   = icf_pkg::byte_of(count_ff, idx[1:0]);
         trailer_in = 1'b1;
         bad_in     = bad_cur;
         left_in    = left_cur - 1'b1;
         if (left_cur == icf_pkg::LEFT_W'(1)) begin
            cmd.last   = 1'b1;
            count_in   = '0;
            phase_in   = '0;
            trailer_in = 1'b0;
            left_in    = '0;
            check_in   = 1'b0;
            bad_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         phase_ff   <= '0;
         trailer_ff <= 1'b0;
         left_ff    <= '0;
         check_ff   <= 1'b0;
         bad_ff     <= 1'b0;
      end else if (accept) begin
         count_ff   <= count_in;
         phase_ff   <= phase_in;
         trailer_ff <= trailer_in;
         left_ff    <= left_in;
         check_ff   <= check_in;
         bad_ff     <= bad_in;
      end
   end

endmodule

/* rtl/icf_cmd_fifo.sv */
// short command queue between front end and back end
module icf_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  icf_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output icf_pkg::cmd_type  head_cmd
);

   icf_pkg::cmd_type                entry_ff [icf_pkg::CMD_DEPTH];
   logic [icf_pkg::CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [icf_pkg::CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [icf_pkg::CMD_CNT_W-1:0]   cnt_ff, cnt_in;

   assign full      = (cnt_ff == icf_pkg::CMD_CNT_W'(icf_pkg::CMD_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == icf_pkg::CMD_PTR_W'(icf_pkg::CMD_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == icf_pkg::CMD_PTR_W'(icf_pkg::CMD_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/icf_back.sv */
// back end: runs the crc, builds output bytes, holds config and output register
module icf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [0:0]        csr_addr,
   input  logic [31:0]       csr_wdata,
   input  logic              cmd_valid,
   input  icf_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast
);

   logic [31:0]   poly_ff;
   logic [31:0]   magic_ff;
   logic [31:0]   crc_ff, crc_in;
   logic          valid_ff, valid_in;
   logic [7:0]    byte_ff, byte_in;
   logic          trailer_ff, trailer_in;
   logic          last_ff, last_in;
   logic [1:0]    status_ff, status_in;

   assign cmd_pop    = cmd_valid && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = {status_ff, trailer_ff};
   assign rsp_tlast  = last_ff;

   always_comb begin
      crc_in     = crc_ff;
      valid_in   = valid_ff && !rsp_tready;
      byte_in    = byte_ff;
      trailer_in = trailer_ff;
      last_in    = last_ff;
      status_in  = status_ff;
      if (cmd_pop) begin
         valid_in   = 1'b1;
         trailer_in = 1'b1;
         last_in    = cmd.last;
         status_in  = cmd.status;
         case (cmd.kind)
            icf_pkg::CMD_DATA: begin
               crc_in     = icf_pkg::crc_byte(crc_ff, cmd.data, icf_pkg::swap32(poly_ff));
               byte_in    = cmd.data;
               trailer_in = 1'b0;
            end
            icf_pkg::CMD_PAD:   byte_in = icf_pkg::PAD_BYTE;
            icf_pkg::CMD_LEN:   byte_in = cmd.data;
            icf_pkg::CMD_MAGIC: byte_in = icf_pkg::byte_of(magic_ff, cmd.sel);
            icf_pkg::CMD_CRC:   byte_in = icf_pkg::byte_of(~crc_ff, cmd.sel);
            default: begin
               byte_in    = 8'd0;
               trailer_in = 1'b0;
            end
         endcase
         if (cmd.last) begin
            crc_in = icf_pkg::CRC_INIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff  <= icf_pkg::CRC_POLY_RESET;
         magic_ff <= icf_pkg::MAGIC_WORD_RESET;
         crc_ff   <= icf_pkg::CRC_INIT;
         valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (icf_pkg::reg_index_type'(csr_addr))
               icf_pkg::REG_CRC_POLY:   poly_ff  <= csr_wdata;
               icf_pkg::REG_MAGIC_WORD: magic_ff <= csr_wdata;
               default:                 magic_ff <= magic_ff;
            endcase
         end
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      trailer_ff <= trailer_in;
      last_ff    <= last_in;
      status_ff  <= status_in;
   end

endmodule

/* rtl/image_crc_pad_footer_framer.sv */
// top level of the image framer: crc-32, 0xff padding and 12-byte footer
//
// req channel: one item per byte. req_tuser[0] selects data (0) or a trailer
// pull (1); data bytes pass through and fold into a reflected crc-32.
// req_tuser[1] on the first data byte turns on the lzma header check.
// each pull returns the next trailer byte: 0xff padding until length + 12
// is a multiple of the block size, then length, magic word and final crc,
// each little-endian. the final footer byte carries rsp_tlast and re-arms.
// rsp channel: one item back for every accepted item, in order.
// rsp_tuser[0] flags trailer bytes, rsp_tuser[2:1] carries the status
// (ok, header mismatch, data refused during trailer).
// csr port: write-only, index 0 crc polynomial, index 1 magic word; write
// only while no item is in flight.
// accept to rsp_tvalid passes the command queue and the back-end output register;
// throughput 1 item per cycle while rsp_tready is high.
// reset clears frame state, loads the register defaults and empties the queue.
// when rsp_tready is low the output register holds, the 2-entry command
// queue fills, and req_tready drops once it is full.
module image_crc_pad_footer_framer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [0] mode, [1] check_header
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [2:0]  rsp_tuser,   // [0] is_trailer, [2:1] status
   output logic        rsp_tlast,   // last footer byte of the frame
   // configuration writes
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   icf_pkg::cmd_type  front_cmd;
   icf_pkg::cmd_type  head_cmd;
   logic              req_accept;
   logic              fifo_full;
   logic              fifo_not_empty;
   logic              cmd_pop;

   // input side stalls only on a full command queue
   assign req_tready = !fifo_full;
   assign req_accept = req_tvalid && req_tready;

   // classify the item and advance frame state
   icf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .mode         (req_tuser[0]),
      .data_byte    (req_tdata),
      .check_header (req_tuser[1]),
      .cmd          (front_cmd)
   );

   // decouples the front end from output back-pressure
   icf_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_cmd  (front_cmd),
      .pop       (cmd_pop),
      .full      (fifo_full),
      .not_empty (fifo_not_empty),
      .head_cmd  (head_cmd)
   );

   // crc, footer byte select and the registered output
   icf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd_valid  (fifo_not_empty),
      .cmd        (head_cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/icf_checker.sv */
// port-level checks for the image framer, bound to the top level
module icf_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // frame close is always a trailer byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("tlast on a non-trailer byte");

   // refused item gives a blank result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:1] == icf_pkg::STATUS_REFUSED |-> rsp_tdata == 8'd0 &&
      !rsp_tuser[0] && !rsp_tlast)
      else $error("refused item with payload");

   // no result straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind image_crc_pad_footer_framer icf_checker u_icf_checker (.*);
